// File: src/fifo_queue_with_search_assert.svh
// Assertion macros for the word queue with search.
// Taken in by the RTL files that check their own control logic.
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define FQS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define FQS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FQS_CHECK(lbl, cond, msg)
`define FQS_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// File: src/fqs_pkg.sv
// Shared types and codes of the word queue with search.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package fqs_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  // Request codes
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic        [1:0]        req_type;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]         status;
    logic signed [WORD_W-1:0]  popped_value;
    logic                      found;
    logic        [COUNT_W-1:0] count;
    logic                      head_valid;
    logic signed [WORD_W-1:0]  head_value;
  } out_item_t;

endpackage

// File: src/fqs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/fifo_queue_with_search.sv
// Bounded first-in first-out queue of signed 32-bit words with a search
// request; top level, uses fqs_pkg, fqs_ram and the assertion header. Words
// live in one RAM with a registered read; the oldest word is also kept in
// a register. Push, refused push or pop, a pop that empties the queue, a
// search of an empty queue and an unused code finish in the idle state. A
// pop that leaves words goes on to a read state that waits on the RAM read
// of the new oldest word. A search walks the held words in a search state
// until a match, examining at most the count, so at most DEPTH, words, one
// word per cycle through the single RAM read port. Each result is registered
// into the output register, or into a skid stage behind it while the output
// is stalled; the next item is taken while a result waits, unless the skid stage is full.
`timescale 1ns / 1ps
`include "fifo_queue_with_search_assert.svh"

module fifo_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fqs_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fqs_pkg::out_item_t out_data
);

  import fqs_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_POPRD = 3'b010,
    ST_SRCH  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_idx_r, head_idx_nxt;
  logic [IDX_W-1:0]   tail_idx_r, tail_idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0]  head_val_r, head_val_nxt;
  logic [WORD_W-1:0]  key_r, key_nxt;
  logic [WORD_W-1:0]  pop_val_r, pop_val_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;

  logic               out_valid_r, skid_valid_r;
  out_item_t          out_r, skid_r;

  logic               accept, out_take, fin, hit;
  out_item_t          fin_item;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // Word store
  fqs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Take items only when idle and the skid stage is free
  assign in_stall  = (state_r != ST_IDLE) || skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign hit       = (ram_rdata == key_r);

  // Request sequencing and result assembly
  always_comb begin
    state_nxt    = state_r;
    head_idx_nxt = head_idx_r;
    tail_idx_nxt = tail_idx_r;
    cnt_nxt      = cnt_r;
    head_val_nxt = head_val_r;
    key_nxt      = key_r;
    pop_val_nxt  = pop_val_r;
    scan_idx_nxt = scan_idx_r;
    left_nxt     = left_r;
    ram_we       = 1'b0;
    ram_waddr    = tail_idx_r;
    ram_wdata    = in_data.value;
    ram_raddr    = scan_idx_r;
    fin          = 1'b0;
    // Default report: queue unchanged
    fin_item              = '0;
    fin_item.status       = STAT_OK;
    fin_item.count        = COUNT_W'(cnt_r);
    fin_item.head_valid   = (cnt_r != '0);
    fin_item.head_value   = (cnt_r != '0) ? head_val_r : '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_PUSH: begin
              fin = 1'b1;
              if (cnt_r == FULL_CNT) begin
                fin_item.status = STAT_FULL;
              end else begin
                ram_we       = 1'b1;
                tail_idx_nxt = inc_idx(tail_idx_r);
                cnt_nxt      = cnt_r + 1'b1;
                if (cnt_r == '0) begin
                  head_val_nxt = in_data.value;
                end
                fin_item.count      = COUNT_W'(cnt_nxt);
                fin_item.head_valid = 1'b1;
                fin_item.head_value = (cnt_r == '0) ? in_data.value : head_val_r;
              end
            end
            REQ_POP: begin
              if (cnt_r == '0) begin
                fin             = 1'b1;
                fin_item.status = STAT_EMPTY;
              end else begin
                head_idx_nxt = inc_idx(head_idx_r);
                cnt_nxt      = cnt_r - 1'b1;
                if (cnt_r == ONE_CNT) begin
                  // Last word leaves: nothing to fetch
                  fin                   = 1'b1;
                  fin_item.popped_value = head_val_r;
                  fin_item.count        = '0;
                  fin_item.head_valid   = 1'b0;
                  fin_item.head_value   = '0;
                end else begin
                  // Fetch the new oldest word
                  ram_raddr   = head_idx_nxt;
                  pop_val_nxt = head_val_r;
                  state_nxt   = ST_POPRD;
                end
              end
            end
            REQ_SEARCH: begin
              if (cnt_r == '0) begin
                fin = 1'b1;
              end else begin
                // Start the walk at the oldest word
                ram_raddr    = head_idx_r;
                scan_idx_nxt = inc_idx(head_idx_r);
                left_nxt     = cnt_r;
                key_nxt      = in_data.value;
                state_nxt    = ST_SRCH;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_POPRD: begin
        // Latch the fetched head and report the pop
        head_val_nxt          = ram_rdata;
        fin                   = 1'b1;
        fin_item.popped_value = pop_val_r;
        fin_item.head_value   = ram_rdata;
        state_nxt             = ST_IDLE;
      end
      ST_SRCH: begin
        if (hit || (left_r == ONE_CNT)) begin
          fin            = 1'b1;
          fin_item.found = hit;
          state_nxt      = ST_IDLE;
        end else begin
          // Advance to the next held word
          ram_raddr    = scan_idx_r;
          scan_idx_nxt = inc_idx(scan_idx_r);
          left_nxt     = left_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_idx_r <= '0;
      tail_idx_r <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      head_idx_r <= head_idx_nxt;
      tail_idx_r <= tail_idx_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    head_val_r <= head_val_nxt;
    key_r      <= key_nxt;
    pop_val_r  <= pop_val_nxt;
    scan_idx_r <= scan_idx_nxt;
    left_r     <= left_nxt;
  end

  // Output register and skid stage: hold while stalled, advance on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (fin) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      if (!out_valid_r || out_take) begin
        out_r <= fin_item;
      end else begin
        skid_r <= fin_item;
      end
    end else if (out_take && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  // Checks
  `FQS_CHECK(a_cnt_bound, cnt_r <= FULL_CNT, "held count exceeds depth")
  `FQS_IMPLY(a_empty_ptrs, cnt_r == '0, head_idx_r == tail_idx_r, "empty queue with split pointers")
  `FQS_IMPLY(a_skid_idle, skid_valid_r, out_valid_r && (state_r == ST_IDLE), "skid item while busy")
  `FQS_IMPLY(a_scan_left, state_r == ST_SRCH, (left_r != '0) && (left_r <= cnt_r), "search walk out of range")

endmodule
